@@ rtl/arrt_pkg.sv @@
`default_nettype none

package arrt_pkg;

    // Default number of region slots in the table.
    localparam int REGION_SLOTS_DEF = 64;

    // Item kinds on the input channel.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_OVERLAP  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_LOOKUP   = 2'd3;

    // One stored region.
    typedef struct packed {
        logic [63:0] rgn_start;
        logic [63:0] rgn_end;
        logic [31:0] rgn_flags;
    } arrt_entry_t;

    // Port controls from the sequencer to the region store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } arrt_mem_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } arrt_state_t;

endpackage

`default_nettype wire

@@ rtl/arrt_mem.sv @@
`default_nettype none

module arrt_mem
    import arrt_pkg::*;
#(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    localparam int IDX_W = $clog2(REGION_SLOTS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire arrt_mem_ctl_t     ctl,
    input  wire logic [IDX_W-1:0]  rd_addr,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire arrt_entry_t       wr_data,
    output arrt_entry_t            rd_data,
    output logic                   rd_valid
);

    arrt_entry_t              mem_reg [REGION_SLOTS];
    arrt_entry_t              rd_data_reg;
    logic [REGION_SLOTS-1:0]  valid_reg;
    logic                     rd_valid_reg;

    // Region payload storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Occupancy bits are flops so that reset empties the table at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

@@ rtl/arrt_cmp.sv @@
`default_nettype none

module arrt_cmp
    import arrt_pkg::*;
(
    input  wire logic        kind,
    input  wire logic [63:0] region_start,
    input  wire logic [63:0] region_end,
    input  wire logic [63:0] lookup_address,
    input  wire arrt_entry_t entry,
    output logic             match
);

    logic [63:0] key;
    logic        key_ge_start;
    logic        key_lt_end;
    logic        end_gt_start;

    // A find tests the address; an insert tests the new region's start.
    assign key          = (kind == KIND_FIND) ? lookup_address : region_start;
    assign key_ge_start = (key >= entry.rgn_start);
    assign key_lt_end   = (key < entry.rgn_end);
    assign end_gt_start = (region_end > entry.rgn_start);

    always_comb
    begin
        if (kind == KIND_FIND)
        begin
            match = key_ge_start && key_lt_end;
        end
        else
        begin
            // Overlap, or a start that falls inside the stored region.
            match = (end_gt_start && key_lt_end) || (key_ge_start && key_lt_end);
        end
    end

endmodule

`default_nettype wire

@@ rtl/address_region_range_table_core.sv @@
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | kind, region_start, region_end, region_flags,
//         |           |                    | lookup_address
// out     | output    | out_valid/out_stall| status, hit, found_start, found_end,
//         |           |                    | found_flags, found_slot, region_count
//
// One comparator visits one slot per cycle through the single read port of the
// region store, then the resolve step resolves the transaction and writes.
// in_stall is high from acceptance until the result is loaded into the output
// register; a result held by out_stall blocks only the resolve step of the next item.
// Reset empties the table at once through per-slot valid flops; no clearing pass.

module address_region_range_table_core
    import arrt_pkg::*;
#(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [63:0] region_start,
    input  wire logic [63:0] region_end,
    input  wire logic [31:0] region_flags,
    input  wire logic [63:0] lookup_address,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             hit,
    output logic [63:0]      found_start,
    output logic [63:0]      found_end,
    output logic [31:0]      found_flags,
    output logic [5:0]       found_slot,
    output logic [6:0]       region_count
);

    localparam int IDX_W = $clog2(REGION_SLOTS);
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(REGION_SLOTS);

    // Sequencer state and scan bookkeeping.
    arrt_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_reg, chk_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              clash_reg, clash_next;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    arrt_entry_t       match_entry_reg, match_entry_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Latched input transaction.
    logic              item_kind_reg;
    logic [63:0]       item_start_reg;
    logic [63:0]       item_end_reg;
    logic [31:0]       item_flags_reg;
    logic [63:0]       item_addr_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_hit_reg, out_hit_next;
    arrt_entry_t       out_entry_reg, out_entry_next;
    logic [IDX_W-1:0]  out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              in_accept;
    logic              out_free;
    arrt_mem_ctl_t     mem_ctl;
    arrt_entry_t       wr_entry;
    arrt_entry_t       rd_entry;
    logic              rd_valid;
    logic              cmp_match;
    logic [IDX_W+5:0]  slot_ext;
    logic [CNT_W+6:0]  count_ext;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign wr_entry.rgn_start = item_start_reg;
    assign wr_entry.rgn_end   = item_end_reg;
    assign wr_entry.rgn_flags = item_flags_reg;

    arrt_mem #(
        .REGION_SLOTS(REGION_SLOTS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .wr_addr  (free_idx_reg),
        .wr_data  (wr_entry),
        .rd_data  (rd_entry),
        .rd_valid (rd_valid)
    );

    // The one comparator, shared by every slot of the scan.
    arrt_cmp u_cmp (
        .kind           (item_kind_reg),
        .region_start   (item_start_reg),
        .region_end     (item_end_reg),
        .lookup_address (item_addr_reg),
        .entry          (rd_entry),
        .match          (cmp_match)
    );

    // Sequencer: issue one slot read per cycle, judge it in the cycle after, and
    // resolve the transaction once the last slot has been judged.
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        chk_next         = 1'b0;
        chk_idx_next     = chk_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        clash_next       = clash_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_entry_next = match_entry_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_hit_next     = out_hit_reg;
        out_entry_next   = out_entry_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;
        mem_ctl.rd_en    = 1'b0;
        mem_ctl.wr_en    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next       = S_SCAN;
                    idx_next         = '0;
                    free_found_next  = 1'b0;
                    clash_next       = 1'b0;
                    match_found_next = 1'b0;
                end
            end

            S_SCAN:
            begin
                if (idx_reg != SLOTS_C)
                begin
                    mem_ctl.rd_en = 1'b1;
                    chk_next      = 1'b1;
                    chk_idx_next  = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (!chk_reg)
                begin
                    state_next = S_RESOLVE;
                end

                if (chk_reg)
                begin
                    if (rd_valid)
                    begin
                        if (cmp_match)
                        begin
                            clash_next = 1'b1;
                            if (!match_found_reg)
                            begin
                                match_found_next = 1'b1;
                                match_idx_next   = chk_idx_reg;
                                match_entry_next = rd_entry;
                            end
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
            end

            S_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b0;
                    out_entry_next = '0;
                    out_slot_next  = '0;
                    if (item_kind_reg == KIND_FIND)
                    begin
                        out_status_next = ST_LOOKUP;
                        if (match_found_reg)
                        begin
                            out_hit_next   = 1'b1;
                            out_entry_next = match_entry_reg;
                            out_slot_next  = match_idx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else if (clash_reg)
                    begin
                        out_status_next = ST_OVERLAP;
                    end
                    else
                    begin
                        out_status_next = ST_INSERTED;
                        out_slot_next   = free_idx_reg;
                        mem_ctl.wr_en   = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                    out_count_next = count_next;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            chk_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            clash_reg       <= 1'b0;
            match_found_reg <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            chk_reg         <= chk_next;
            free_found_reg  <= free_found_next;
            clash_reg       <= clash_next;
            match_found_reg <= match_found_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= chk_idx_next;
        free_idx_reg    <= free_idx_next;
        match_idx_reg   <= match_idx_next;
        match_entry_reg <= match_entry_next;
        out_status_reg  <= out_status_next;
        out_hit_reg     <= out_hit_next;
        out_entry_reg   <= out_entry_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
        if (in_accept)
        begin
            item_kind_reg  <= kind;
            item_start_reg <= region_start;
            item_end_reg   <= region_end;
            item_flags_reg <= region_flags;
            item_addr_reg  <= lookup_address;
        end
    end

    // The slot and count fields keep the low bits of the internal values.
    assign slot_ext  = {6'd0, out_slot_reg};
    assign count_ext = {7'd0, out_count_reg};

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign hit          = out_hit_reg;
    assign found_start  = out_entry_reg.rgn_start;
    assign found_end    = out_entry_reg.rgn_end;
    assign found_flags  = out_entry_reg.rgn_flags;
    assign found_slot   = slot_ext[5:0];
    assign region_count = count_ext[6:0];

    // The table never holds more regions than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
    else $error("region count exceeds slot count");

    // A slot is written only for an insert that found a free slot and no clash.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (item_kind_reg == KIND_INSERT) && free_found_reg && !clash_reg)
    else $error("region written without a successful insert");

    // Each successful insert raises the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |=> count_reg == $past(count_reg) + 1'b1)
    else $error("region count did not follow an insert");

    // A find miss reports slot zero and no region.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_LOOKUP && !out_hit_reg)
            |-> (out_slot_reg == '0) && (out_entry_reg == '0))
    else $error("find miss carries region data");

    // A result is loaded only when the previous one has left the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_status_reg))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ tb/tb_address_region_range_table_core.sv @@
module tb_address_region_range_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import arrt_pkg::*;

    // The block scans one slot per cycle. The tail after the last result
    // covers the time of two whole transactions.
    localparam int SLOTS        = REGION_SLOTS_DEF;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int TAIL_CYCLES  = 2 * (SLOTS + 3);
    localparam int LONG_HOLD    = 500;
    localparam int MAX_SHOWN    = 10;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One request as it is offered on the input channel.
    typedef struct packed {
        logic        kind;
        logic [63:0] base;
        logic [63:0] limit;
        logic [31:0] flags;
        logic [63:0] addr;
    } region_req_t;

    // One result as it leaves the output channel.
    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [63:0] base;
        logic [63:0] limit;
        logic [31:0] flags;
        logic [5:0]  slot;
        logic [6:0]  count;
    } region_rsp_t;

    // All block inputs start at known values before the first edge.
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        kind           = 1'b0;
    logic [63:0] region_start   = '0;
    logic [63:0] region_end     = '0;
    logic [31:0] region_flags   = '0;
    logic [63:0] lookup_address = '0;
    logic        out_stall      = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_start;
    logic [63:0] found_end;
    logic [31:0] found_flags;
    logic [5:0]  found_slot;
    logic [6:0]  region_count;

    // Shadow copy of the region table, advanced once per accepted transaction.
    logic        tbl_used  [SLOTS];
    logic [63:0] tbl_base  [SLOTS];
    logic [63:0] tbl_limit [SLOTS];
    logic [31:0] tbl_flags [SLOTS];
    int          tbl_count;

    // Results still owed by the block, oldest first.
    region_rsp_t expected_results[$];

    // Directed rows: request, whether the result is written out by hand, and that result.
    region_req_t dir_req[$];
    bit          dir_typed[$];
    region_rsp_t dir_rsp[$];

    // Idling controls shared by the sender, the receiver and the phase sequencer.
    int send_gap_max = 12;
    int recv_gap_max = 12;
    int hold_request = 0;

    int mismatches   = 0;
    int results_seen = 0;
    int hits_seen    = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int cycle_count  = 0;

    address_region_range_table_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .region_start   (region_start),
        .region_end     (region_end),
        .region_flags   (region_flags),
        .lookup_address (lookup_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .hit            (hit),
        .found_start    (found_start),
        .found_end      (found_end),
        .found_flags    (found_flags),
        .found_slot     (found_slot),
        .region_count   (region_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic region_req_t mk_req(input logic k, input logic [63:0] b,
                                           input logic [63:0] l, input logic [31:0] f,
                                           input logic [63:0] a);
        region_req_t r;
        r = '{kind: k, base: b, limit: l, flags: f, addr: a};
        return r;
    endfunction

    function automatic region_rsp_t mk_rsp(input logic [1:0] st, input logic h,
                                           input logic [63:0] b, input logic [63:0] l,
                                           input logic [31:0] f, input logic [5:0] s,
                                           input logic [6:0] c);
        region_rsp_t o;
        o = '{status: st, hit: h, base: b, limit: l, flags: f, slot: s, count: c};
        return o;
    endfunction

    task automatic add_row(input region_req_t r, input bit typed, input region_rsp_t o);
        dir_req.push_back(r);
        dir_typed.push_back(typed);
        dir_rsp.push_back(o);
    endtask

    // Applies one transaction to the shadow table and returns the result the
    // block must give. An insert looks for the lowest free slot and a clash with
    // any stored region; a full table wins over a clash. A start that falls
    // inside a stored region is a clash even when the new region is inverted.
    // A find reports the lowest slot whose half-open range holds the address.
    function automatic region_rsp_t apply_region_op(input region_req_t r);
        region_rsp_t o;
        int          free_idx;
        bit          clash;
        o = '0;
        free_idx = -1;
        clash = 1'b0;
        if (r.kind == KIND_INSERT)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_used[i])
                begin
                    if ((r.limit > tbl_base[i] && r.base < tbl_limit[i]) ||
                        (r.base >= tbl_base[i] && r.base < tbl_limit[i]))
                        clash = 1'b1;
                end
                else if (free_idx < 0)
                begin
                    free_idx = i;
                end
            end
            if (free_idx < 0)
                o.status = ST_FULL;
            else if (clash)
                o.status = ST_OVERLAP;
            else
            begin
                tbl_used[free_idx]  = 1'b1;
                tbl_base[free_idx]  = r.base;
                tbl_limit[free_idx] = r.limit;
                tbl_flags[free_idx] = r.flags;
                tbl_count++;
                o.status = ST_INSERTED;
                o.slot = free_idx[5:0];
            end
        end
        else
        begin
            o.status = ST_LOOKUP;
            // Walking downward leaves the lowest matching slot in place.
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (tbl_used[i] && r.addr >= tbl_base[i] && r.addr < tbl_limit[i])
                begin
                    o.hit = 1'b1;
                    o.base = tbl_base[i];
                    o.limit = tbl_limit[i];
                    o.flags = tbl_flags[i];
                    o.slot = i[5:0];
                end
            end
        end
        o.count = tbl_count[6:0];
        return o;
    endfunction

    // Draws one random request. Every field starts fully random so that each
    // bit toggles; finds then mostly aim at the edges or the inside of a stored
    // region, and inserts are mostly shapes that collide with a stored region.
    // Fresh inserts are either random small regions or regions that touch a
    // stored one without overlapping. The rest of the inserts are pure noise.
    function automatic region_req_t draw_region_req(input int find_pct, input int fresh_pct);
        region_req_t r;
        int          pick;
        int          shape;
        logic [63:0] b;
        logic [63:0] l;
        logic [63:0] mid_addr;
        logic [63:0] small_len;
        r.kind  = ($urandom_range(99, 0) < find_pct) ? KIND_FIND : KIND_INSERT;
        r.base  = {$urandom, $urandom};
        r.limit = {$urandom, $urandom};
        r.flags = $urandom;
        r.addr  = {$urandom, $urandom};
        // Stored slots are always 0 .. tbl_count-1, since nothing is ever removed.
        pick = (tbl_count > 0) ? $urandom_range(tbl_count - 1, 0) : 0;
        b = tbl_base[pick];
        l = tbl_limit[pick];
        mid_addr = (b < l) ? b + ({$urandom, $urandom} % (l - b)) : b;
        small_len = {32'd0, $urandom_range(4096, 1)};
        if (r.kind == KIND_FIND)
        begin
            if (tbl_count > 0 && $urandom_range(9, 0) < 7)
            begin
                case ($urandom_range(4, 0))
                    0: r.addr = b;
                    1: r.addr = l - 64'd1;
                    2: r.addr = l;
                    3: r.addr = b - 64'd1;
                    default: r.addr = mid_addr;
                endcase
            end
        end
        else
        begin
            shape = $urandom_range(99, 0);
            if (shape < fresh_pct)
            begin
                case ((tbl_count > 0) ? $urandom_range(2, 0) : 0)
                    0: r.limit = r.base + small_len;
                    1:
                    begin
                        r.base = l;
                        r.limit = l + small_len;
                    end
                    default:
                    begin
                        r.base = b - small_len;
                        r.limit = b;
                    end
                endcase
            end
            else if (tbl_count > 0 && shape < 92)
            begin
                case ($urandom_range(4, 0))
                    0:
                    begin
                        r.base = b;
                        r.limit = l;
                    end
                    1: r.base = mid_addr;
                    2:
                    begin
                        r.base = b - small_len;
                        r.limit = b + 64'd1;
                    end
                    3:
                    begin
                        r.base = b - small_len;
                        r.limit = l + small_len;
                    end
                    default:
                    begin
                        r.base = mid_addr;
                        r.limit = mid_addr - small_len;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Offers one transaction after a random gap and holds it until the block
    // takes it. in_valid is lowered only when a gap follows, so a back-to-back
    // transaction never sees the valid dropped and raised within one step.
    // The expectation is queued at the accepting edge.
    task automatic offer_item(input region_req_t r, input bit typed, input region_rsp_t hand);
        int          gap;
        region_rsp_t predicted;
        gap = (send_gap_max > 0) ? $urandom_range(send_gap_max, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= r.kind;
        region_start   <= r.base;
        region_end     <= r.limit;
        region_flags   <= r.flags;
        lookup_address <= r.addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_region_op(r);
        expected_results.push_back(typed ? hand : predicted);
    endtask

    // Runs one stretch of random traffic with its own idling profile. A nonzero
    // hold asks the receiver for one long stall so that the block backs up and
    // raises in_stall while the sender keeps offering.
    task automatic run_phase(input int n, input int find_pct, input int fresh_pct,
                             input int sgap, input int rgap, input int hold);
        send_gap_max = sgap;
        recv_gap_max = rgap;
        hold_request = hold;
        repeat (n)
            offer_item(draw_region_req(find_pct, fresh_pct), 1'b0, '0);
    endtask

    // Receiver: stalls for a random number of cycles (or one long stretch when
    // asked), then takes the next result and checks it against the oldest
    // expectation, field by field.
    initial
    begin : result_sink
        int          wait_cycles;
        region_rsp_t got;
        region_rsp_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request > 0)
            begin
                wait_cycles = hold_request;
                hold_request = 0;
            end
            else
            begin
                wait_cycles = (recv_gap_max > 0) ? $urandom_range(recv_gap_max, 0) : 0;
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            got = {status, hit, found_start, found_end, found_flags, found_slot, region_count};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("result %0d arrived with no transaction pending: status=%0d",
                             results_seen, got.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.hit !== want.hit ||
                    got.base !== want.base || got.limit !== want.limit ||
                    got.flags !== want.flags || got.slot !== want.slot ||
                    got.count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("result %0d differs:", results_seen);
                        $display("  expected status=%0d hit=%0d start=%h end=%h flags=%h slot=%0d count=%0d",
                                 want.status, want.hit, want.base, want.limit, want.flags,
                                 want.slot, want.count);
                        $display("  actual   status=%0d hit=%0d start=%h end=%h flags=%h slot=%0d count=%0d",
                                 got.status, got.hit, got.base, got.limit, got.flags,
                                 got.slot, got.count);
                    end
                end
                status_tally[want.status]++;
                if (want.hit)
                    hits_seen++;
            end
        end
    end

    // Sequencer: reset, the directed table, five random phases, then drain.
    initial
    begin : stimulus
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_base[i]  = '0;
            tbl_limit[i] = '0;
            tbl_flags[i] = '0;
        end
        tbl_count = 0;

        // Lookups into the empty table miss at both address extremes.
        add_row(mk_req(KIND_FIND, 0, 0, 0, 0), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(KIND_FIND, 0, 0, 0, ALL_ONES), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 0));
        // First region lands in slot 0; its first and last addresses hit,
        // the address just past it and the one just below it miss.
        add_row(mk_req(KIND_INSERT, 64'h1000, 64'h2000, 32'hFFFF_FFFF, 0), 1,
                mk_rsp(ST_INSERTED, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h1000), 1,
                mk_rsp(ST_LOOKUP, 1, 64'h1000, 64'h2000, 32'hFFFF_FFFF, 0, 1));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h1FFF), 1,
                mk_rsp(ST_LOOKUP, 1, 64'h1000, 64'h2000, 32'hFFFF_FFFF, 0, 1));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h2000), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h0FFF), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 1));
        // Partial overlap and a region that swallows the stored one are rejected.
        add_row(mk_req(KIND_INSERT, 64'h1800, 64'h2800, 32'h1234_5678, 0), 1,
                mk_rsp(ST_OVERLAP, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(KIND_INSERT, 64'h0700, 64'h2100, 32'h1234_5678, 0), 1,
                mk_rsp(ST_OVERLAP, 0, 0, 0, 0, 0, 1));
        // A region that ends exactly where another starts is accepted.
        add_row(mk_req(KIND_INSERT, 64'h0800, 64'h1000, 32'h0000_0001, 0), 1,
                mk_rsp(ST_INSERTED, 0, 0, 0, 0, 1, 2));
        // Region reaching up to the top address.
        add_row(mk_req(KIND_INSERT, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES, 32'h0, 0), 1,
                mk_rsp(ST_INSERTED, 0, 0, 0, 0, 2, 3));
        // Inverted region whose start lies inside a stored region is an overlap.
        add_row(mk_req(KIND_INSERT, 64'h1500, 64'h1400, 32'h0, 0), 1,
                mk_rsp(ST_OVERLAP, 0, 0, 0, 0, 0, 3));
        // Empty and inverted regions clear of the others are stored but never hit.
        add_row(mk_req(KIND_INSERT, 0, 0, 32'h5A5A_5A5A, 0), 1,
                mk_rsp(ST_INSERTED, 0, 0, 0, 0, 3, 4));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 0), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 4));
        add_row(mk_req(KIND_INSERT, ALL_ONES, 0, 32'hA5A5_A5A5, 0), 1,
                mk_rsp(ST_INSERTED, 0, 0, 0, 0, 4, 5));
        add_row(mk_req(KIND_FIND, 0, 0, 0, ALL_ONES), 1, mk_rsp(ST_LOOKUP, 0, 0, 0, 0, 0, 5));
        add_row(mk_req(KIND_FIND, 0, 0, 0, ALL_ONES - 64'd1), 1,
                mk_rsp(ST_LOOKUP, 1, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES, 32'h0, 2, 5));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h0800), 1,
                mk_rsp(ST_LOOKUP, 1, 64'h0800, 64'h1000, 32'h0000_0001, 1, 5));
        add_row(mk_req(KIND_FIND, 0, 0, 0, 64'h0FFF), 1,
                mk_rsp(ST_LOOKUP, 1, 64'h0800, 64'h1000, 32'h0000_0001, 1, 5));
        // Region whose end reaches one address into a stored region.
        add_row(mk_req(KIND_INSERT, 0, 64'h0801, 32'h0, 0), 1,
                mk_rsp(ST_OVERLAP, 0, 0, 0, 0, 0, 5));
        // Rows with random content are left to the predictor.
        add_row(mk_req(KIND_INSERT, 64'h4000, 64'h5000, $urandom, {$urandom, $urandom}), 0, '0);
        add_row(mk_req(KIND_FIND, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                       64'h4000 + {52'd0, 12'($urandom_range(4095, 0))}), 0, '0);
        add_row(mk_req(KIND_FIND, 0, 0, 0, {$urandom, $urandom}), 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_req.size(); i++)
            offer_item(dir_req[i], dir_typed[i], dir_rsp[i]);

        // Slow growth with full idling, then a burst with no idling and a long
        // receiver hold, then a fill to capacity, then traffic against a full
        // table, and a last stretch with another long hold.
        run_phase(300, 60,  4, 12, 12, 0);
        run_phase(250, 60,  4,  0,  0, LONG_HOLD);
        run_phase(300, 40, 40, 12,  0, 0);
        run_phase(300, 50, 20,  0, 12, 0);
        run_phase(300, 70, 10, 12, 12, LONG_HOLD);
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d stored, %0d overlap rejects, %0d full rejects",
                 results_seen, status_tally[ST_INSERTED], status_tally[ST_OVERLAP],
                 status_tally[ST_FULL]);
        $display("%0d lookups with %0d hits, %0d regions held at the end, %0d mismatches",
                 status_tally[ST_LOOKUP], hits_seen, tbl_count, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/arrt_pkg.sv
rtl/arrt_mem.sv
rtl/arrt_cmp.sv
rtl/address_region_range_table_core.sv
tb/tb_address_region_range_table_core.sv
